// ===== src/huffman_code_bit_packer_defines.svh =====
// Assertion macros shared by the Huffman bit packer RTL.
`ifndef HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define HCBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define HCBP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define HCBP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/hcbp_pkg.sv =====
// Types and constants of the Huffman code bit packer.
package hcbp_pkg;

  localparam int OCT_W   = 8;
  localparam int WORD_W  = 32;
  localparam int LEN_W   = 6;
  localparam int ENTRY_W = LEN_W + WORD_W;
  localparam int OUT_MAX = 4;
  localparam int CNT_W   = 3;
  localparam int PEND_W  = 7;
  localparam int MODE_W  = 2;
  localparam int IN_W    = 48;

  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;

  typedef struct packed {
    logic vld;
    logic flush;
    logic hit;
  } stage_t;

endpackage

// ===== src/huffman_code_bit_packer.sv =====
// Huffman code bit packer: code table, MSB-first bit packer and byte output buffer.
//
// A load request writes one symbol's code word and length into a 256-entry
// table, an encode request appends that symbol's code to the pending bits and
// emits every completed byte, and a flush request pads any pending bits with
// zeros and emits them as a final byte; tlast marks the final byte of each request.
// The table is read into a register when the request is taken, and the packing is
// registered into the output buffer when that stage advances; it waits while an
// earlier request's bytes are held, until the last of them is taken. One request
// is taken per cycle while m_axis_tready is high, as long as it yields at most one
// byte; a request that yields several bytes offers them one byte at a time, and a
// following request that yields bytes waits behind it.
// The length store is tracked by one valid bit per entry that reset clears at
// once, so no clearing pass is needed and the block is ready right after reset.
`include "huffman_code_bit_packer_defines.svh"

module huffman_code_bit_packer #(
  parameter int SYMBOLS      = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // symbol[7:0], code_word[39:8], code_length[45:40], zeros[47:46]
  input  logic [hcbp_pkg::IN_W-1:0]   s_axis_tdata,
  // mode[1:0]
  input  logic [hcbp_pkg::MODE_W-1:0] s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // out_byte[7:0]
  output logic [hcbp_pkg::OCT_W-1:0]  m_axis_tdata,
  output logic                        m_axis_tlast
);

  localparam int IDX_W     = $clog2(SYMBOLS);
  localparam int LEN_LIMIT = (MAX_CODE_LEN < hcbp_pkg::WORD_W) ? MAX_CODE_LEN : hcbp_pkg::WORD_W;

  logic [hcbp_pkg::MODE_W-1:0] in_mode;
  logic [7:0]                  in_sym;
  logic [hcbp_pkg::WORD_W-1:0] in_word;
  logic [hcbp_pkg::LEN_W-1:0]  in_len;
  logic                        in_acc;
  logic                        in_range;
  logic [IDX_W-1:0]            idx;
  logic [hcbp_pkg::LEN_W-1:0]  len_sat;
  logic [hcbp_pkg::WORD_W-1:0] word_mask;

  logic [hcbp_pkg::ENTRY_W-1:0] mem_q [SYMBOLS];
  logic [SYMBOLS-1:0]           valid_q;
  logic [hcbp_pkg::ENTRY_W-1:0] rd_q;
  hcbp_pkg::stage_t             s1_q;

  logic [hcbp_pkg::PEND_W-1:0] pend_bits_q;
  logic [hcbp_pkg::CNT_W-1:0]  pend_cnt_q;

  logic [hcbp_pkg::OCT_W-1:0]  out_buf_q [hcbp_pkg::OUT_MAX];
  logic [hcbp_pkg::CNT_W-1:0]  out_cnt_q;
  logic [1:0]                  out_idx_q;
  logic                        out_last;

  logic [hcbp_pkg::LEN_W-1:0]  eff_len;
  logic [hcbp_pkg::WORD_W-1:0] eff_code;
  logic [hcbp_pkg::LEN_W-1:0]  total;
  logic [38:0]                 comb_bits;
  logic [39:0]                 left_bits;
  logic [hcbp_pkg::CNT_W-1:0]  nbytes;
  logic [2:0]                  rem;
  logic [hcbp_pkg::PEND_W-1:0] new_pend;
  logic [hcbp_pkg::OCT_W-1:0]  oct_w [hcbp_pkg::OUT_MAX];
  logic                        buf_free;
  logic                        s1_adv;
  logic                        pop;

  assign in_mode  = s_axis_tuser;
  assign in_sym   = s_axis_tdata[7:0];
  assign in_word  = s_axis_tdata[39:8];
  assign in_len   = s_axis_tdata[45:40];
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_range = ({1'b0, in_sym} < 9'(SYMBOLS));
  assign idx      = in_sym[IDX_W-1:0];
  assign len_sat  = (in_len > 6'(LEN_LIMIT)) ? 6'(LEN_LIMIT) : in_len;
  assign word_mask = 32'((33'd1 << len_sat) - 33'd1);

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_mode == hcbp_pkg::MODE_LOAD) && in_range) begin
      mem_q[idx] <= {len_sat, in_word & word_mask};
    end
    if (in_acc && (in_mode == hcbp_pkg::MODE_ENCODE)) begin
      rd_q <= mem_q[idx];
    end
  end

  always_comb begin
    eff_len  = '0;
    eff_code = '0;
    if (s1_q.flush) begin
      if (pend_cnt_q != '0) begin
        eff_len = 6'(4'd8 - {1'b0, pend_cnt_q});
      end
    end else if (s1_q.hit) begin
      eff_len  = rd_q[hcbp_pkg::ENTRY_W-1:hcbp_pkg::WORD_W];
      eff_code = rd_q[hcbp_pkg::WORD_W-1:0];
    end
    total     = 6'(pend_cnt_q) + eff_len;
    comb_bits = (39'(pend_bits_q) << eff_len) | 39'(eff_code);
    left_bits = 40'(comb_bits) << (6'd40 - total);
    nbytes    = total[5:3];
    rem       = total[2:0];
    new_pend  = comb_bits[6:0] & 7'((8'd1 << rem) - 8'd1);
    for (int k = 0; k < hcbp_pkg::OUT_MAX; k++) begin
      oct_w[k] = left_bits[39 - 8 * k -: 8];
    end
  end

  assign m_axis_tvalid = (out_cnt_q != '0);
  assign out_last      = ({1'b0, out_idx_q} == (out_cnt_q - 3'd1));
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = out_buf_q[out_idx_q];
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign buf_free      = (out_cnt_q == '0) || (pop && out_last);
  assign s1_adv        = s1_q.vld && ((nbytes == '0) || buf_free);
  assign s_axis_tready = !s1_q.vld || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      s1_q        <= '0;
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      out_cnt_q   <= '0;
      out_idx_q   <= '0;
    end else begin
      if (in_acc && (in_mode == hcbp_pkg::MODE_LOAD) && in_range) begin
        valid_q[idx] <= 1'b1;
      end
      if (s_axis_tready) begin
        s1_q.vld   <= in_acc && ((in_mode == hcbp_pkg::MODE_ENCODE) ||
                                 (in_mode == hcbp_pkg::MODE_FLUSH));
        s1_q.flush <= (in_mode == hcbp_pkg::MODE_FLUSH);
        s1_q.hit   <= valid_q[idx] && in_range;
      end
      if (s1_adv) begin
        pend_bits_q <= new_pend;
        pend_cnt_q  <= rem;
      end
      if (s1_adv && (nbytes != '0)) begin
        out_cnt_q <= nbytes;
        out_idx_q <= '0;
      end else if (pop) begin
        if (out_last) begin
          out_cnt_q <= '0;
          out_idx_q <= '0;
        end else begin
          out_idx_q <= out_idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && (nbytes != '0)) begin
      out_buf_q <= oct_w;
    end
  end

  `HCBP_ASSERT(a_out_cnt_max, out_cnt_q <= 3'd4, "Output buffer holds more than four bytes.")
  `HCBP_ASSERT(a_pend_clean, (pend_bits_q >> pend_cnt_q) == 7'd0, "Stale bits above pending count.")
  `HCBP_ASSERT_IMP(a_buf_free, s1_adv && (nbytes != 3'd0), buf_free, "Buffer overwritten while busy.")
  `HCBP_ASSERT_NXT(a_flush_empty, s1_adv && s1_q.flush, pend_cnt_q == 3'd0, "Flush left bits pending.")

endmodule
